@@ rtl/core/cqrf_pkg.sv @@
// ----------------------------------------------------------------------------
// cqrf_pkg
// Shared codes and types for the clipped quad rectangle fill engine.
// ----------------------------------------------------------------------------
package cqrf_pkg;

    // Item modes
    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_VERTEX = 2'd1,
        MODE_READ   = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;
    localparam int CFG_DATA_W = 9;

    localparam int PIXEL_W = 32;

    // Fill request handed to the address sequencer
    typedef struct packed {
        logic start;
        logic clear;
        logic empty;
    } t_fill_ctl;

endpackage

@@ rtl/core/clipped_quad_rect_fill.sv @@
// ----------------------------------------------------------------------------
// clipped_quad_rect_fill
// Framebuffer fill engine: frame clear, clipped quad bounding-box fill and
// single pixel read over one frame store.
// ----------------------------------------------------------------------------
//   channel   direction  handshake            payload
//   item      in         i_start / o_busy     i_mode, i_pos_*, i_clip_*,
//                                             i_fill_rgba, i_read_x, i_read_y
//   result    out        o_valid (strobe)     o_pixel_value, o_outside_frame
//   config    in         i_cfg_we             i_cfg_idx, i_cfg_wdata
//
// Read items do not raise busy; a read result strobes in the cycle after the
// item is taken. Only the fourth vertex raises busy: through r_pend_a and
// r_pend_b in setup, then the address state and the pixel sweep of the
// clipped box when it is not empty. Clear holds busy through the address
// state and a sweep of the whole frame, and not at all when it has no area.
// The fill rate is set by the single write port of the frame store. Reset
// is synchronous and needs no clearing pass; the result side cannot stall.
// ----------------------------------------------------------------------------
module clipped_quad_rect_fill
    import cqrf_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic [1:0]            i_mode,
    input  logic signed [15:0]    i_pos_x,
    input  logic signed [15:0]    i_pos_y,
    input  logic signed [15:0]    i_clip_left,
    input  logic signed [15:0]    i_clip_top,
    input  logic signed [15:0]    i_clip_right,
    input  logic signed [15:0]    i_clip_bottom,
    input  logic [31:0]           i_fill_rgba,
    input  logic [7:0]            i_read_x,
    input  logic [7:0]            i_read_y,
    output logic                  o_valid,
    output logic [31:0]           o_pixel_value,
    output logic                  o_outside_frame,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int EWW   = (WW > CFG_DATA_W) ? WW : CFG_DATA_W;
    localparam int EHW   = (HW > CFG_DATA_W) ? HW : CFG_DATA_W;
    localparam int RXW   = (WW > 8) ? WW : 8;
    localparam int RYW   = (HW > 8) ? HW : 8;
    localparam int PW    = (WW + 9 > AW) ? WW + 9 : AW;

    logic [CFG_DATA_W-1:0] r_frame_width, r_frame_height;
    logic [EWW-1:0]        fw_ext;
    logic [EHW-1:0]        fh_ext;
    logic [WW-1:0]         w_eff;
    logic [HW-1:0]         h_eff;
    logic                  accept;
    logic                  go_clear, go_vertex, go_read;
    t_mode                 mode;
    logic                  setup_busy, seq_busy;
    t_fill_ctl             setup_ctl, fill_ctl;
    logic [WW-1:0]         setup_x0, setup_x1, fill_x0, fill_x1;
    logic [HW-1:0]         setup_y0, setup_y1, fill_y0, fill_y1;
    logic [PIXEL_W-1:0]    setup_color;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr, mem_raddr;
    logic [PIXEL_W-1:0]    mem_wdata, mem_rdata;
    logic [PW-1:0]         rd_lin;
    logic                  rd_outside;
    logic                  r_rd_valid, r_rd_outside;

    // Take configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= '0;
            r_frame_height <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_wdata;
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Saturate the frame size at the store limits
    assign fw_ext = EWW'(r_frame_width);
    assign fh_ext = EHW'(r_frame_height);
    assign w_eff  = (fw_ext > EWW'(MAX_WIDTH))  ? WW'(MAX_WIDTH)  : fw_ext[WW-1:0];
    assign h_eff  = (fh_ext > EHW'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : fh_ext[HW-1:0];

    // Decode the accepted item
    assign accept = i_start && !o_busy;
    assign mode   = t_mode'(i_mode);

    always_comb begin
        go_clear  = 1'b0;
        go_vertex = 1'b0;
        go_read   = 1'b0;
        unique case (mode)
            MODE_CLEAR:  go_clear  = accept;
            MODE_VERTEX: go_vertex = accept;
            MODE_READ:   go_read   = accept;
            MODE_NONE:   ;
            default:     ;
        endcase
    end

    cqrf_quad_setup #(
        .WW(WW),
        .HW(HW)
    ) u_setup (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_vtx        (go_vertex),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_clip_left  (i_clip_left),
        .i_clip_top   (i_clip_top),
        .i_clip_right (i_clip_right),
        .i_clip_bottom(i_clip_bottom),
        .i_fill_rgba  (i_fill_rgba),
        .i_width      (w_eff),
        .i_height     (h_eff),
        .o_busy       (setup_busy),
        .o_ctl        (setup_ctl),
        .o_x0         (setup_x0),
        .o_y0         (setup_y0),
        .o_x1         (setup_x1),
        .o_y1         (setup_y1),
        .o_color      (setup_color)
    );

    // Clear sweeps the whole frame with zero
    always_comb begin
        if (go_clear) begin
            fill_ctl.start = 1'b1;
            fill_ctl.clear = 1'b1;
            fill_ctl.empty = (w_eff == '0) || (h_eff == '0);
            fill_x0        = '0;
            fill_y0        = '0;
            fill_x1        = w_eff;
            fill_y1        = h_eff;
        end else begin
            fill_ctl       = setup_ctl;
            fill_x0        = setup_x0;
            fill_y0        = setup_y0;
            fill_x1        = setup_x1;
            fill_y1        = setup_y1;
        end
    end

    cqrf_fill_seq #(
        .WW(WW),
        .HW(HW),
        .AW(AW)
    ) u_fill (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (fill_ctl),
        .i_x0   (fill_x0),
        .i_y0   (fill_y0),
        .i_x1   (fill_x1),
        .i_y1   (fill_y1),
        .i_width(w_eff),
        .i_color(setup_color),
        .o_busy (seq_busy),
        .o_we   (mem_we),
        .o_waddr(mem_waddr),
        .o_wdata(mem_wdata)
    );

    // Form the read address and the bounds flag
    assign rd_lin     = PW'(i_read_y) * PW'(w_eff) + PW'(i_read_x);
    assign mem_raddr  = rd_lin[AW-1:0];
    assign rd_outside = (RXW'(i_read_x) >= RXW'(w_eff)) || (RYW'(i_read_y) >= RYW'(h_eff));

    cqrf_frame_mem #(
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_re   (go_read),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    // Strobe the read result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= go_read;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go_read) begin
            r_rd_outside <= rd_outside;
        end
    end

    assign o_busy          = setup_busy || seq_busy;
    assign o_valid         = r_rd_valid;
    assign o_outside_frame = r_rd_outside;
    assign o_pixel_value   = r_rd_outside ? '0 : mem_rdata;

endmodule

@@ rtl/core/cqrf_frame_mem.sv @@
// ----------------------------------------------------------------------------
// cqrf_frame_mem
// Frame store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cqrf_frame_mem
    import cqrf_pkg::*;
#(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  logic [PIXEL_W-1:0] i_wdata,
    input  logic               i_re,
    input  logic [AW-1:0]      i_raddr,
    output logic [PIXEL_W-1:0] o_rdata
);

    logic [PIXEL_W-1:0] r_mem [DEPTH];
    logic [PIXEL_W-1:0] r_rdata;

    // Write one pixel beat
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, updated only while i_re is high
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/cqrf_quad_setup.sv @@
// ----------------------------------------------------------------------------
// cqrf_quad_setup
// Quad corner collection, bounding box, frame clamp and clip intersection.
// ----------------------------------------------------------------------------
module cqrf_quad_setup
    import cqrf_pkg::*;
#(
    parameter int WW = 9,
    parameter int HW = 9
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vtx,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic signed [15:0] i_clip_left,
    input  logic signed [15:0] i_clip_top,
    input  logic signed [15:0] i_clip_right,
    input  logic signed [15:0] i_clip_bottom,
    input  logic [PIXEL_W-1:0] i_fill_rgba,
    input  logic [WW-1:0]      i_width,
    input  logic [HW-1:0]      i_height,
    output logic               o_busy,
    output t_fill_ctl          o_ctl,
    output logic [WW-1:0]      o_x0,
    output logic [HW-1:0]      o_y0,
    output logic [WW-1:0]      o_x1,
    output logic [HW-1:0]      o_y1,
    output logic [PIXEL_W-1:0] o_color
);

    localparam int WHW = (WW > HW) ? WW : HW;
    localparam int CW  = (WHW + 1 > 13) ? WHW + 1 : 13;

    // Truncate Q12.4 toward zero to whole pixels
    function automatic logic signed [CW-1:0] f_trunc(input logic signed [15:0] v);
        logic signed [16:0] t;
        t = {v[15], v};
        if (v < 0) begin
            t = t + 17'sd15;
        end
        return CW'(t >>> 4);
    endfunction

    function automatic logic signed [CW-1:0] f_max(input logic signed [CW-1:0] a,
                                                   input logic signed [CW-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic signed [CW-1:0] f_min(input logic signed [CW-1:0] a,
                                                   input logic signed [CW-1:0] b);
        return (a < b) ? a : b;
    endfunction

    logic [1:0]         r_count;
    logic               r_pend_a;
    logic               r_pend_b;
    logic signed [15:0] r_min_x, r_min_y, r_max_x, r_max_y;
    logic signed [15:0] r_clip_l, r_clip_t, r_clip_r, r_clip_b;
    logic [PIXEL_W-1:0] r_color;
    logic signed [CW-1:0] r_x0, r_y0, r_x1, r_y1;
    logic signed [CW-1:0] n_x0, n_y0, n_x1, n_y1;
    logic signed [CW-1:0] w_s, h_s;

    // Count corners, launch the box pipeline on the fourth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_pend_a <= 1'b0;
            r_pend_b <= 1'b0;
        end else begin
            r_pend_a <= i_vtx && (r_count == 2'd3);
            r_pend_b <= r_pend_a;
            if (i_vtx) begin
                r_count <= r_count + 2'd1;
            end
        end
    end

    // Latch clip and color on the first corner, widen the box after
    always_ff @(posedge i_clk) begin
        if (i_vtx) begin
            if (r_count == 2'd0) begin
                r_clip_l <= i_clip_left;
                r_clip_t <= i_clip_top;
                r_clip_r <= i_clip_right;
                r_clip_b <= i_clip_bottom;
                r_color  <= i_fill_rgba;
                r_min_x  <= i_pos_x;
                r_min_y  <= i_pos_y;
                r_max_x  <= i_pos_x;
                r_max_y  <= i_pos_y;
            end else begin
                r_min_x  <= (i_pos_x < r_min_x) ? i_pos_x : r_min_x;
                r_min_y  <= (i_pos_y < r_min_y) ? i_pos_y : r_min_y;
                r_max_x  <= (i_pos_x > r_max_x) ? i_pos_x : r_max_x;
                r_max_y  <= (i_pos_y > r_max_y) ? i_pos_y : r_max_y;
            end
        end
    end

    // Clamp to the frame and intersect with the clip
    always_comb begin
        w_s  = CW'($signed({1'b0, i_width}));
        h_s  = CW'($signed({1'b0, i_height}));
        n_x0 = f_max(f_max('0, f_trunc(r_min_x)), f_trunc(r_clip_l));
        n_y0 = f_max(f_max('0, f_trunc(r_min_y)), f_trunc(r_clip_t));
        n_x1 = f_min(f_min(w_s, f_trunc(r_max_x)), f_trunc(r_clip_r));
        n_y1 = f_min(f_min(h_s, f_trunc(r_max_y)), f_trunc(r_clip_b));
    end

    always_ff @(posedge i_clk) begin
        if (r_pend_a) begin
            r_x0 <= n_x0;
            r_y0 <= n_y0;
            r_x1 <= n_x1;
            r_y1 <= n_y1;
        end
    end

    // Hand the clipped box to the sequencer
    always_comb begin
        o_ctl.start = r_pend_b;
        o_ctl.clear = 1'b0;
        o_ctl.empty = (r_x1 <= r_x0) || (r_y1 <= r_y0);
    end

    assign o_x0    = r_x0[WW-1:0];
    assign o_y0    = r_y0[HW-1:0];
    assign o_x1    = r_x1[WW-1:0];
    assign o_y1    = r_y1[HW-1:0];
    assign o_color = r_color;
    assign o_busy  = r_pend_a || r_pend_b;

endmodule

@@ rtl/core/cqrf_fill_seq.sv @@
// ----------------------------------------------------------------------------
// cqrf_fill_seq
// Rectangle address sequencer: writes one pixel per cycle row by row.
// ----------------------------------------------------------------------------
module cqrf_fill_seq
    import cqrf_pkg::*;
#(
    parameter int WW = 9,
    parameter int HW = 9,
    parameter int AW = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_fill_ctl          i_ctl,
    input  logic [WW-1:0]      i_x0,
    input  logic [HW-1:0]      i_y0,
    input  logic [WW-1:0]      i_x1,
    input  logic [HW-1:0]      i_y1,
    input  logic [WW-1:0]      i_width,
    input  logic [PIXEL_W-1:0] i_color,
    output logic               o_busy,
    output logic               o_we,
    output logic [AW-1:0]      o_waddr,
    output logic [PIXEL_W-1:0] o_wdata
);

    localparam int PW = (HW + WW + 1 > AW) ? HW + WW + 1 : AW;

    typedef enum logic [2:0] {
        FS_IDLE = 3'b001,
        FS_ADDR = 3'b010,
        FS_FILL = 3'b100
    } t_fill_state;

    t_fill_state        r_state, n_state;
    logic [WW-1:0]      r_x, r_x0, r_x1;
    logic [HW-1:0]      r_y, r_y1;
    logic [AW-1:0]      r_addr, r_row;
    logic [PIXEL_W-1:0] r_color;
    logic [PW-1:0]      start_lin;
    logic [PW-1:0]      next_row;
    logic               last_col, last_row;

    assign start_lin = PW'(r_y) * PW'(i_width) + PW'(r_x0);
    assign next_row  = PW'(r_row) + PW'(i_width);
    assign last_col  = (WW'(r_x + 1'b1) == r_x1);
    assign last_row  = (HW'(r_y + 1'b1) == r_y1);

    // Advance through start address, then the pixel sweep
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            FS_IDLE: begin
                if (i_ctl.start && !i_ctl.empty) begin
                    n_state = FS_ADDR;
                end
            end
            FS_ADDR: n_state = FS_FILL;
            FS_FILL: begin
                if (last_col && last_row) begin
                    n_state = FS_IDLE;
                end
            end
            default: n_state = FS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold the box and step the write address
    always_ff @(posedge i_clk) begin
        case (r_state)
            FS_IDLE: begin
                if (i_ctl.start) begin
                    r_x0    <= i_x0;
                    r_x1    <= i_x1;
                    r_y1    <= i_y1;
                    r_x     <= i_x0;
                    r_y     <= i_y0;
                    r_color <= i_ctl.clear ? '0 : i_color;
                end
            end
            FS_ADDR: begin
                r_addr <= start_lin[AW-1:0];
                r_row  <= start_lin[AW-1:0];
            end
            FS_FILL: begin
                if (last_col) begin
                    r_x    <= r_x0;
                    r_y    <= HW'(r_y + 1'b1);
                    r_row  <= next_row[AW-1:0];
                    r_addr <= next_row[AW-1:0];
                end else begin
                    r_x    <= WW'(r_x + 1'b1);
                    r_addr <= AW'(r_addr + 1'b1);
                end
            end
            default: ;
        endcase
    end

    assign o_busy  = (r_state != FS_IDLE);
    assign o_we    = (r_state == FS_FILL);
    assign o_waddr = r_addr;
    assign o_wdata = r_color;

endmodule

@@ sim/clipped_quad_rect_fill_tb.sv @@
// ----------------------------------------------------------------------------
// clipped_quad_rect_fill_tb
// Self-checking bench for the quad rectangle fill engine. A shadow frame store
// tracks clears and clipped box fills. Each read result is checked against
// it or its table row, field by field. A short table of corner cases runs
// first, then random quads, reads and clears over a series of frame sizes.
// ----------------------------------------------------------------------------
module clipped_quad_rect_fill_tb;
    import cqrf_pkg::*;

    localparam int FB_MAX_W        = 256;
    localparam int FB_MAX_H        = 256;
    localparam int FB_DEPTH        = FB_MAX_W * FB_MAX_H;
    localparam int SMALL_AREA      = 4096;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 90;
    localparam int CALM_PHASE      = 6;
    localparam int PH_W [PHASES]   = '{12, 256, 0, 5, 511, 1, 31, 300, 9, 16};
    localparam int PH_H [PHASES]   = '{10, 256, 9, 0, 7, 256, 17, 511, 40, 2};

    typedef struct {
        t_mode              mode;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] clip_l;
        logic signed [15:0] clip_t;
        logic signed [15:0] clip_r;
        logic signed [15:0] clip_b;
        logic [31:0]        rgba;
        logic [7:0]         rd_x;
        logic [7:0]         rd_y;
    } t_item;

    typedef struct {
        logic [31:0] pixel;
        logic        outside;
    } t_read_beat;

    typedef struct {
        bit         is_cfg;
        t_item      it;
        logic [8:0] cfg_w;
        logic [8:0] cfg_h;
        bit         typed;
        t_read_beat want;
    } t_stim_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_start;
    logic                  o_busy;
    logic [1:0]            i_mode;
    logic signed [15:0]    i_pos_x;
    logic signed [15:0]    i_pos_y;
    logic signed [15:0]    i_clip_left;
    logic signed [15:0]    i_clip_top;
    logic signed [15:0]    i_clip_right;
    logic signed [15:0]    i_clip_bottom;
    logic [31:0]           i_fill_rgba;
    logic [7:0]            i_read_x;
    logic [7:0]            i_read_y;
    logic                  o_valid;
    logic [31:0]           o_pixel_value;
    logic                  o_outside_frame;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    // Shadow of the block state
    logic [31:0] shadow_fb [FB_DEPTH];
    logic [8:0]  fb_width_reg;
    logic [8:0]  fb_height_reg;
    logic [1:0]  corners_seen;
    int          box_lo_x, box_lo_y, box_hi_x, box_hi_y;
    int          lat_cl, lat_ct, lat_cr, lat_cb;
    logic [31:0] lat_rgba;
    int          safe_span;     // entries 0 .. safe_span-1 hold known data

    t_read_beat  read_q [$];
    t_read_beat  no_want;
    t_read_beat  mon_want;
    int          err_count;
    int          reads_checked;
    int          quads_filled;
    int          clears_done;
    int          items_sent;
    bit          calm;
    int          anchor_x, anchor_y, anchor_span;

    clipped_quad_rect_fill dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_mode          (i_mode),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_clip_left     (i_clip_left),
        .i_clip_top      (i_clip_top),
        .i_clip_right    (i_clip_right),
        .i_clip_bottom   (i_clip_bottom),
        .i_fill_rgba     (i_fill_rgba),
        .i_read_x        (i_read_x),
        .i_read_y        (i_read_y),
        .o_valid         (o_valid),
        .o_pixel_value   (o_pixel_value),
        .o_outside_frame (o_outside_frame),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #400_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic int lo_i(int a, int b);
        return (a < b) ? a : b;
    endfunction

    function automatic int hi_i(int a, int b);
        return (a > b) ? a : b;
    endfunction

    // Saturate the size registers to the store limits
    function automatic int eff_w();
        return (int'(fb_width_reg) > FB_MAX_W) ? FB_MAX_W : int'(fb_width_reg);
    endfunction

    function automatic int eff_h();
        return (int'(fb_height_reg) > FB_MAX_H) ? FB_MAX_H : int'(fb_height_reg);
    endfunction

    function automatic bit small_frame();
        return eff_w() * eff_h() <= SMALL_AREA;
    endfunction

    // Fill the truncated, clamped and clipped corner box with the latched color
    function automatic void paint_box();
        int w, h, x0, y0, x1, y1, cx0, cy0, cx1, cy1, x, y;
        w   = eff_w();
        h   = eff_h();
        x0  = hi_i(0, box_lo_x / 16);
        y0  = hi_i(0, box_lo_y / 16);
        x1  = lo_i(w, box_hi_x / 16);
        y1  = lo_i(h, box_hi_y / 16);
        cx0 = (lat_cl > 0) ? lat_cl / 16 : 0;
        cy0 = (lat_ct > 0) ? lat_ct / 16 : 0;
        cx1 = (lat_cr < w * 16) ? lat_cr / 16 : w;
        cy1 = (lat_cb < h * 16) ? lat_cb / 16 : h;
        x0  = hi_i(x0, cx0);
        y0  = hi_i(y0, cy0);
        x1  = lo_i(x1, cx1);
        y1  = lo_i(y1, cy1);
        for (y = y0; y < y1; y++) begin
            for (x = x0; x < x1; x++) begin
                shadow_fb[y * w + x] = lat_rgba;
            end
        end
    endfunction

    // Advance the shadow state by one item; return 1 when it yields a read beat
    function automatic bit step_framebuf(input t_item it, output t_read_beat res);
        int w, h, i, px, py, rx, ry;
        w           = eff_w();
        h           = eff_h();
        res.pixel   = '0;
        res.outside = 1'b0;
        case (it.mode)
            MODE_CLEAR: begin
                for (i = 0; i < w * h; i++) shadow_fb[i] = '0;
                if (w * h > safe_span) safe_span = w * h;
                clears_done++;
            end
            MODE_VERTEX: begin
                px = int'(it.pos_x);
                py = int'(it.pos_y);
                if (corners_seen == 2'd0) begin
                    lat_cl   = int'(it.clip_l);
                    lat_ct   = int'(it.clip_t);
                    lat_cr   = int'(it.clip_r);
                    lat_cb   = int'(it.clip_b);
                    lat_rgba = it.rgba;
                    box_lo_x = px;
                    box_lo_y = py;
                    box_hi_x = px;
                    box_hi_y = py;
                end else begin
                    box_lo_x = lo_i(box_lo_x, px);
                    box_lo_y = lo_i(box_lo_y, py);
                    box_hi_x = hi_i(box_hi_x, px);
                    box_hi_y = hi_i(box_hi_y, py);
                end
                if (corners_seen == 2'd3) begin
                    paint_box();
                    quads_filled++;
                    corners_seen = 2'd0;
                end else begin
                    corners_seen = corners_seen + 2'd1;
                end
            end
            MODE_READ: begin
                rx = int'(it.rd_x);
                ry = int'(it.rd_y);
                if (rx >= w || ry >= h) begin
                    res.outside = 1'b1;
                end else begin
                    res.pixel = shadow_fb[ry * w + rx];
                end
                return 1'b1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    // Item with every field but the mode random; callers overwrite what matters
    function automatic t_item mk_plain(input t_mode m);
        t_item it;
        it.mode   = m;
        it.pos_x  = 16'($urandom);
        it.pos_y  = 16'($urandom);
        it.clip_l = 16'($urandom);
        it.clip_t = 16'($urandom);
        it.clip_r = 16'($urandom);
        it.clip_b = 16'($urandom);
        it.rgba   = $urandom;
        it.rd_x   = 8'($urandom);
        it.rd_y   = 8'($urandom);
        return it;
    endfunction

    function automatic t_item mk_vertex(int px, int py, int cl, int ct, int cr, int cb,
                                        logic [31:0] rgba);
        t_item it;
        it        = mk_plain(MODE_VERTEX);
        it.pos_x  = 16'(px);
        it.pos_y  = 16'(py);
        it.clip_l = 16'(cl);
        it.clip_t = 16'(ct);
        it.clip_r = 16'(cr);
        it.clip_b = 16'(cb);
        it.rgba   = rgba;
        return it;
    endfunction

    function automatic t_item mk_read(int rx, int ry);
        t_item it;
        it      = mk_plain(MODE_READ);
        it.rd_x = 8'(rx);
        it.rd_y = 8'(ry);
        return it;
    endfunction

    // Mostly in-frame reads; every in-frame entry lies below safe_span
    function automatic t_item pick_read();
        if (eff_w() > 0 && eff_h() > 0 && $urandom_range(0, 99) < 75)
            return mk_read($urandom_range(0, eff_w() - 1), $urandom_range(0, eff_h() - 1));
        return mk_read($urandom_range(0, 255), $urandom_range(0, 255));
    endfunction

    // Choose where the next group of corners lands and how far it spreads
    function automatic void pick_anchor();
        int lim;
        lim         = small_frame() ? hi_i(eff_w(), eff_h()) + 4 : 20;
        anchor_span = $urandom_range(0, lim);
        anchor_x    = int'($urandom_range(0, eff_w() + 6)) - 3;
        anchor_y    = int'($urandom_range(0, eff_h() + 6)) - 3;
    endfunction

    // Q12.4 value near a pixel, straddling zero to exercise truncation
    function automatic int near_q4(int base_px);
        return base_px * 16 + int'($urandom_range(0, anchor_span * 16 + 15)) - 8;
    endfunction

    function automatic t_item anchored_vertex();
        int cl, ct, cr, cb;
        case ($urandom_range(0, 3))
            0: begin
                cl = -32768;
                ct = -32768;
                cr = 32767;
                cb = 32767;
            end
            1, 2: begin
                cl = near_q4(anchor_x - 1);
                ct = near_q4(anchor_y - 1);
                cr = cl + int'($urandom_range(0, (anchor_span + 2) * 16));
                cb = ct + int'($urandom_range(0, (anchor_span + 2) * 16));
            end
            default: begin
                // inverted clip: no area
                cl = near_q4(anchor_x);
                ct = near_q4(anchor_y);
                cr = cl - int'($urandom_range(0, 64));
                cb = ct - int'($urandom_range(0, 64));
            end
        endcase
        return mk_vertex(near_q4(anchor_x), near_q4(anchor_y), cl, ct, cr, cb, $urandom);
    endfunction

    function automatic t_stim_row row_item(input t_item it);
        t_stim_row row;
        row.is_cfg = 1'b0;
        row.it     = it;
        row.cfg_w  = '0;
        row.cfg_h  = '0;
        row.typed  = 1'b0;
        row.want   = no_want;
        return row;
    endfunction

    function automatic t_stim_row row_read(int rx, int ry, logic [31:0] pix, logic outside);
        t_stim_row row;
        row              = row_item(mk_read(rx, ry));
        row.typed        = 1'b1;
        row.want.pixel   = pix;
        row.want.outside = outside;
        return row;
    endfunction

    function automatic t_stim_row row_cfg(logic [8:0] w, logic [8:0] h);
        t_stim_row row;
        row        = row_item(mk_plain(MODE_NONE));
        row.is_cfg = 1'b1;
        row.cfg_w  = w;
        row.cfg_h  = h;
        return row;
    endfunction

    // Present one item, hold it until taken, then predict its outcome
    task automatic drive_item(input t_item it, input bit typed, input t_read_beat want);
        int         gap;
        t_read_beat res;
        gap = 0;
        if (!calm) begin
            while ($urandom_range(0, 99) < 15) gap++;
        end
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start       <= 1'b1;
        i_mode        <= it.mode;
        i_pos_x       <= it.pos_x;
        i_pos_y       <= it.pos_y;
        i_clip_left   <= it.clip_l;
        i_clip_top    <= it.clip_t;
        i_clip_right  <= it.clip_r;
        i_clip_bottom <= it.clip_b;
        i_fill_rgba   <= it.rgba;
        i_read_x      <= it.rd_x;
        i_read_y      <= it.rd_y;
        do @(posedge i_clk); while (o_busy);
        if (step_framebuf(it, res)) read_q.push_back(typed ? want : res);
        if (it.mode != MODE_NONE) items_sent++;
    endtask

    // Drop start, drain reads, then let any fill or clear run out
    task automatic wait_idle();
        i_start <= 1'b0;
        repeat (3) @(posedge i_clk);
        while (read_q.size() != 0 || o_busy) @(posedge i_clk);
    endtask

    task automatic write_frame_regs(input logic [8:0] w, input logic [8:0] h);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= REG_FRAME_WIDTH;
        i_cfg_wdata <= w;
        @(posedge i_clk);
        fb_width_reg = w;
        i_cfg_idx   <= REG_FRAME_HEIGHT;
        i_cfg_wdata <= h;
        @(posedge i_clk);
        fb_height_reg = h;
        i_cfg_we    <= 1'b0;
    endtask

    // One quad of four corners, with reads or clears slipped in between
    task automatic send_quad(input bit noisy);
        int k;
        // close a quad left open by a broken run
        while (corners_seen != 2'd0) drive_item(anchored_vertex(), 1'b0, no_want);
        pick_anchor();
        for (k = 0; k < 4; k++) begin
            if (noisy)
                drive_item(mk_vertex($urandom, $urandom, $urandom, $urandom, $urandom,
                                     $urandom, $urandom), 1'b0, no_want);
            else
                drive_item(anchored_vertex(), 1'b0, no_want);
            if (k < 3 && $urandom_range(0, 99) < 12) begin
                if ($urandom_range(0, 3) == 0 && small_frame())
                    drive_item(mk_plain(MODE_CLEAR), 1'b0, no_want);
                else
                    drive_item(pick_read(), 1'b0, no_want);
            end
        end
    endtask

    // Check each read beat against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (read_q.size() == 0) begin
                $display("%0t: read beat with none pending: pixel %h outside %b",
                         $time, o_pixel_value, o_outside_frame);
                err_count++;
            end else begin
                mon_want = read_q.pop_front();
                reads_checked++;
                if (o_pixel_value !== mon_want.pixel) begin
                    $display("%0t: pixel_value expected %h got %h",
                             $time, mon_want.pixel, o_pixel_value);
                    err_count++;
                end
                if (o_outside_frame !== mon_want.outside) begin
                    $display("%0t: outside_frame expected %b got %b",
                             $time, mon_want.outside, o_outside_frame);
                    err_count++;
                end
            end
        end
    end

    initial begin
        t_stim_row tab [$];
        int        p, r, k, base;
        bit        drained;

        i_rst_n       <= 1'b0;
        i_start       <= 1'b0;
        i_mode        <= MODE_CLEAR;
        i_pos_x       <= '0;
        i_pos_y       <= '0;
        i_clip_left   <= '0;
        i_clip_top    <= '0;
        i_clip_right  <= '0;
        i_clip_bottom <= '0;
        i_fill_rgba   <= '0;
        i_read_x      <= '0;
        i_read_y      <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= REG_FRAME_WIDTH;
        i_cfg_wdata   <= '0;
        no_want.pixel   = '0;
        no_want.outside = 1'b0;
        fb_width_reg  = '0;
        fb_height_reg = '0;
        corners_seen  = 2'd0;
        box_lo_x = 0; box_lo_y = 0; box_hi_x = 0; box_hi_y = 0;
        lat_cl = 0; lat_ct = 0; lat_cr = 0; lat_cb = 0;
        lat_rgba      = '0;
        safe_span     = 0;
        err_count     = 0;
        reads_checked = 0;
        quads_filled  = 0;
        clears_done   = 0;
        items_sent    = 0;
        calm          = 1'b0;
        anchor_x      = 0;
        anchor_y      = 0;
        anchor_span   = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty frame after reset: every read lies outside
        tab.push_back(row_read(0, 0, 32'h0, 1'b1));
        tab.push_back(row_read(255, 255, 32'h0, 1'b1));
        tab.push_back(row_item(mk_plain(MODE_NONE)));
        tab.push_back(row_item(mk_plain(MODE_CLEAR)));
        // Extreme corners and clip edges on a frame of no area
        tab.push_back(row_item(mk_vertex(-32768, -32768, -32768, -32768, 32767, 32767,
                                         32'hFFFF_FFFF)));
        tab.push_back(row_item(mk_vertex(32767, 32767, 0, 0, 0, 0, 32'h0)));
        tab.push_back(row_item(mk_vertex(-32768, 32767, 0, 0, 0, 0, 32'h0)));
        tab.push_back(row_item(mk_vertex(32767, -32768, 0, 0, 0, 0, 32'h0)));
        tab.push_back(row_cfg(9'd4, 9'd3));
        tab.push_back(row_item(mk_plain(MODE_CLEAR)));
        tab.push_back(row_read(3, 2, 32'h0, 1'b0));
        tab.push_back(row_read(4, 0, 32'h0, 1'b1));
        // Quad with a clear between corners and fractions straddling zero
        tab.push_back(row_item(mk_vertex(24, 16, 0, 0, 48, 48, 32'hA5A5_5A5A)));
        tab.push_back(row_item(mk_vertex(-8, 40, 0, 0, 0, 0, 32'h0)));
        tab.push_back(row_item(mk_plain(MODE_CLEAR)));
        tab.push_back(row_item(mk_vertex(56, 8, 0, 0, 0, 0, 32'h0)));
        tab.push_back(row_item(mk_vertex(40, 47, 0, 0, 0, 0, 32'h0)));
        tab.push_back(row_item(mk_read(2, 1)));
        // Degenerate quad: all corners on one point leave the frame untouched
        for (k = 0; k < 4; k++)
            tab.push_back(row_item(mk_vertex(32, 32, -32768, -32768, 32767, 32767,
                                             32'h1234_5678)));
        tab.push_back(row_item(mk_read(2, 2)));
        // Oversized width saturates, then a narrower pitch over old data
        tab.push_back(row_cfg(9'd511, 9'd3));
        tab.push_back(row_item(mk_plain(MODE_CLEAR)));
        tab.push_back(row_read(255, 2, 32'h0, 1'b0));
        tab.push_back(row_cfg(9'd2, 9'd3));
        tab.push_back(row_item(mk_read(1, 2)));

        foreach (tab[i]) begin
            if (tab[i].is_cfg) begin
                wait_idle();
                write_frame_regs(tab[i].cfg_w, tab[i].cfg_h);
            end else begin
                drive_item(tab[i].it, tab[i].typed, tab[i].want);
            end
        end

        // Random traffic over a series of frame sizes
        for (p = 0; p < PHASES; p++) begin
            wait_idle();
            write_frame_regs(9'(PH_W[p]), 9'(PH_H[p]));
            calm = (p == CALM_PHASE);
            if (eff_w() * eff_h() > safe_span)
                drive_item(mk_plain(MODE_CLEAR), 1'b0, no_want);
            if (!small_frame()) begin
                // one quad that covers the whole frame
                for (k = 0; k < 4; k++)
                    drive_item(mk_vertex((k % 2) ? eff_w() * 16 + 16 : -16,
                                         (k / 2) ? eff_h() * 16 + 16 : -16,
                                         -32768, -32768, 32767, 32767, $urandom),
                               1'b0, no_want);
            end
            base    = items_sent;
            drained = 1'b0;
            while (items_sent - base < ITEMS_PER_PHASE) begin
                // hold off mid-phase until every read beat is back
                if (!drained && items_sent - base >= ITEMS_PER_PHASE / 2) begin
                    i_start <= 1'b0;
                    do @(posedge i_clk); while (read_q.size() != 0);
                    drained = 1'b1;
                end
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    send_quad(r < 10 && small_frame());
                end else if (r < 85) begin
                    drive_item(pick_read(), 1'b0, no_want);
                end else if (r < 90) begin
                    drive_item(mk_plain(MODE_NONE), 1'b0, no_want);
                end else if (r < 95) begin
                    // broken run of one to three corners
                    pick_anchor();
                    k = $urandom_range(1, 3);
                    repeat (k) drive_item(anchored_vertex(), 1'b0, no_want);
                end else if (small_frame()) begin
                    drive_item(mk_plain(MODE_CLEAR), 1'b0, no_want);
                end else begin
                    drive_item(pick_read(), 1'b0, no_want);
                end
            end
        end

        // Drain outstanding reads; the last fill is not waited for
        i_start <= 1'b0;
        do @(posedge i_clk); while (read_q.size() != 0);
        repeat (4) @(posedge i_clk);

        $display("Ran %0d items over %0d frame sizes: %0d reads checked, %0d quads, %0d clears.",
                 items_sent, PHASES + 3, reads_checked, quads_filled, clears_done);
        if (err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
